[hdl/itoa_pkg.sv]
// Shared types, constants and a helper function for the integer to ASCII converter.
`default_nettype none

package itoa_pkg;

    localparam int VALUE_WIDTH        = 32;
    localparam int RADIX_W            = 6;
    localparam int COUNT_W            = 6;
    localparam int CHAR_W             = 7;
    localparam int DEFAULT_MAX_DIGITS = 32;
    localparam int QUEUE_DEPTH        = 2;

    // The divider retires this many quotient bits per clock.
    localparam int BITS_PER_STEP = 8;
    localparam int DIV_STEPS     = (VALUE_WIDTH + BITS_PER_STEP - 1) / BITS_PER_STEP;
    localparam int DIV_W         = DIV_STEPS * BITS_PER_STEP;

    localparam logic [CHAR_W-1:0]  CH_ZERO   = 7'h30;
    localparam logic [CHAR_W-1:0]  CH_ALPHA  = 7'h41;
    localparam logic [CHAR_W-1:0]  CH_MINUS  = 7'h2D;
    localparam logic [RADIX_W-1:0] DEC_LIMIT = 6'd10;
    localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd36;

    typedef struct packed {
        logic signed [VALUE_WIDTH-1:0] value;
        logic [RADIX_W-1:0]            radix;
        logic [COUNT_W-1:0]            digit_count;
    } itoa_in_t;

    typedef struct packed {
        logic [CHAR_W-1:0] character;
        logic              last;
    } itoa_out_t;

    // One classified conversion job as it waits between front and back.
    typedef struct packed {
        logic [VALUE_WIDTH-1:0] mag;
        logic                   neg;
        logic [RADIX_W-1:0]     radix;
        logic [COUNT_W-1:0]     want;
    } itoa_entry_t;

    function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] d);
        logic [CHAR_W-1:0] c;
        if (d >= DEC_LIMIT) begin
            c = CH_ALPHA + CHAR_W'(d - DEC_LIMIT);
        end else begin
            c = CH_ZERO + CHAR_W'(d);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

[hdl/integer_to_ascii_any_base_core.sv]
// Top level of the integer to ASCII converter for radix 2 to 36.
// The back converts one job at a time, digit by digit through the shared radix divider,
// and then reads the digit store back through its single read port, after an optional minus.
// The queue lets the front accept further jobs while the back is still busy with one.
// Reset: aresetn is synchronous and active low; it empties the queue and the output register.
`default_nettype none

// The block is split in three parts. The front takes input beats, works out the
// sign and the magnitude of the value and clamps the radix into its legal range.
// A two-entry queue holds classified jobs so that the front keeps accepting beats
// while the back is busy. The back divides the magnitude by the radix repeatedly,
// eight quotient bits per cycle, and stores one character per digit, least
// significant first. Once the digit count is reached (or, in automatic mode, the
// quotient has become zero) it emits an optional minus sign and then reads the
// digit store backwards, so that the most significant character leaves first. The
// final character of each conversion carries last. The output beat sits in a
// register of its own, so a stalled result channel never corrupts a beat in flight.
module integer_to_ascii_any_base_core #(
    parameter int unsigned MAX_DIGITS = itoa_pkg::DEFAULT_MAX_DIGITS
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire itoa_pkg::itoa_in_t  s_data,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output itoa_pkg::itoa_out_t      m_data
);
    import itoa_pkg::*;

    // Jobs travelling between the front, the queue and the back.
    itoa_entry_t push_entry;
    itoa_entry_t pop_entry;
    logic        q_push;
    logic        q_full;
    logic        q_pop;
    logic        q_empty;

    itoa_front u_front (
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_entry (push_entry)
    );

    itoa_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (q_pop),
        .pop_entry  (pop_entry),
        .empty      (q_empty)
    );

    // The back owns the digit store; its depth follows MAX_DIGITS.
    itoa_back #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_empty (q_empty),
        .q_entry (pop_entry),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

`default_nettype wire

[hdl/itoa_front.sv]
// Input stage: takes a beat, derives sign and magnitude and clamps the radix.
`default_nettype none

module itoa_front (
    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire itoa_pkg::itoa_in_t     s_data,
    input  wire logic                   q_full,
    output logic                        q_push,
    output itoa_pkg::itoa_entry_t       q_entry
);
    import itoa_pkg::*;

    logic [VALUE_WIDTH-1:0] raw;
    logic                   neg;

    always_comb begin
        raw = s_data.value;
        neg = raw[VALUE_WIDTH-1];
        // The unsigned negation also gives the most negative value's magnitude exactly.
        q_entry.mag = neg ? (~raw + 1'b1) : raw;
        q_entry.neg = neg;
        priority if (s_data.radix < RADIX_MIN) begin
            q_entry.radix = RADIX_MIN;
        end else if (s_data.radix > RADIX_MAX) begin
            q_entry.radix = RADIX_MAX;
        end else begin
            q_entry.radix = s_data.radix;
        end
        q_entry.want = s_data.digit_count;
    end

    assign s_ready = !q_full;
    assign q_push  = s_valid && !q_full;

endmodule

`default_nettype wire

[hdl/itoa_queue.sv]
// Short job queue that decouples the input stage from the converter.
`default_nettype none

module itoa_queue (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   push,
    input  wire itoa_pkg::itoa_entry_t  push_entry,
    output logic                        full,
    input  wire logic                   pop,
    output itoa_pkg::itoa_entry_t       pop_entry,
    output logic                        empty
);
    import itoa_pkg::*;

    localparam int DEPTH = QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

    itoa_entry_t       slot_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign empty     = (count_reg == '0);
    assign pop_entry = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue holds more jobs than it has slots");

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(push && full && !pop))
        else $error("job pushed into a full queue");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(pop && empty))
        else $error("job popped from an empty queue");

endmodule

`default_nettype wire

[hdl/itoa_back.sv]
// Converter: iterative division by the radix, digit store and character output register.
`default_nettype none

module itoa_back #(
    parameter int unsigned MAX_DIGITS = itoa_pkg::DEFAULT_MAX_DIGITS
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   q_empty,
    input  wire itoa_pkg::itoa_entry_t  q_entry,
    output logic                        q_pop,
    output logic                        m_valid,
    input  wire logic                   m_ready,
    output itoa_pkg::itoa_out_t         m_data
);
    import itoa_pkg::*;

    localparam int CNT_W  = $clog2(MAX_DIGITS + 1);
    localparam int ADDR_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
    localparam int LIM_W  = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
    localparam int STEP_W = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DIV_STEPS - 1);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DIV  = 3'd1;
    localparam logic [2:0] ST_SIGN = 3'd2;
    localparam logic [2:0] ST_RD   = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    logic [2:0]          state_reg;
    logic [DIV_W-1:0]    work_reg;
    logic [RADIX_W-1:0]  rem_reg;
    logic [RADIX_W-1:0]  radix_reg;
    logic                neg_reg;
    logic                auto_reg;
    logic [CNT_W-1:0]    limit_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [STEP_W-1:0]   step_reg;
    logic [ADDR_W-1:0]   ptr_reg;
    logic [CHAR_W-1:0]   rd_data_reg;
    logic                m_valid_reg;
    logic [CHAR_W-1:0]   m_char_reg;
    logic                m_last_reg;

    logic [CHAR_W-1:0]   digit_mem [MAX_DIGITS];

    logic [DIV_W-1:0]    work_step;
    logic [RADIX_W-1:0]  rem_step;
    logic [CNT_W-1:0]    cnt_next;
    logic                digit_done;
    logic                conv_done;
    logic                out_free;
    logic                out_load;
    logic [LIM_W-1:0]    want_w;
    logic [LIM_W-1:0]    max_w;
    logic [LIM_W-1:0]    limit_w;

    // Restoring division by the radix, BITS_PER_STEP quotient bits per cycle.
    always_comb begin : div_step
        logic [DIV_W-1:0] w;
        logic [RADIX_W:0] r;
        w = work_reg;
        r = {1'b0, rem_reg};
        for (int k = 0; k < BITS_PER_STEP; k++) begin
            r = {r[RADIX_W-1:0], w[DIV_W-1]};
            w = {w[DIV_W-2:0], 1'b0};
            if (r >= {1'b0, radix_reg}) begin
                r    = r - {1'b0, radix_reg};
                w[0] = 1'b1;
            end
        end
        work_step = w;
        rem_step  = r[RADIX_W-1:0];
    end

    always_comb begin
        want_w  = LIM_W'(q_entry.want);
        max_w   = LIM_W'(MAX_DIGITS);
        limit_w = ((want_w == '0) || (want_w > max_w)) ? max_w : want_w;
    end

    assign cnt_next   = cnt_reg + 1'b1;
    assign digit_done = (state_reg == ST_DIV) && (step_reg == LAST_STEP);
    assign conv_done  = (cnt_next == limit_reg) || (auto_reg && (work_step == '0));
    assign out_free   = !m_valid_reg || m_ready;
    assign out_load   = ((state_reg == ST_SIGN) || (state_reg == ST_OUT)) && out_free;
    assign q_pop      = (state_reg == ST_IDLE) && !q_empty;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (!q_empty) begin
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (digit_done && conv_done) begin
                        state_reg <= neg_reg ? ST_SIGN : ST_RD;
                    end
                end
                ST_SIGN: begin
                    if (out_free) begin
                        state_reg <= ST_RD;
                    end
                end
                ST_RD: begin
                    state_reg <= ST_OUT;
                end
                ST_OUT: begin
                    if (out_free) begin
                        state_reg <= (ptr_reg == '0) ? ST_IDLE : ST_RD;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_IDLE: begin
                if (!q_empty) begin
                    work_reg  <= DIV_W'(q_entry.mag);
                    rem_reg   <= '0;
                    radix_reg <= q_entry.radix;
                    neg_reg   <= q_entry.neg;
                    auto_reg  <= (q_entry.want == '0);
                    limit_reg <= CNT_W'(limit_w);
                    cnt_reg   <= '0;
                    step_reg  <= '0;
                end
            end
            ST_DIV: begin
                work_reg <= work_step;
                if (digit_done) begin
                    rem_reg  <= '0;
                    step_reg <= '0;
                    cnt_reg  <= cnt_next;
                    ptr_reg  <= cnt_reg[ADDR_W-1:0];
                end else begin
                    rem_reg  <= rem_step;
                    step_reg <= step_reg + 1'b1;
                end
            end
            ST_SIGN: begin
                if (out_free) begin
                    m_char_reg <= CH_MINUS;
                    m_last_reg <= 1'b0;
                end
            end
            ST_RD: begin
            end
            ST_OUT: begin
                if (out_free) begin
                    m_char_reg <= rd_data_reg;
                    m_last_reg <= (ptr_reg == '0);
                    if (ptr_reg != '0) begin
                        ptr_reg <= ptr_reg - 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // Digit store, least significant digit at address zero.
    always_ff @(posedge aclk) begin
        if (digit_done) begin
            digit_mem[cnt_reg[ADDR_W-1:0]] <= digit_char(rem_step);
        end
        rd_data_reg <= digit_mem[ptr_reg];
    end

    assign m_valid          = m_valid_reg;
    assign m_data.character = m_char_reg;
    assign m_data.last      = m_last_reg;

    a_rem_below_radix: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV) |-> (rem_reg < radix_reg))
        else $error("partial remainder not below the radix");

    a_radix_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> (radix_reg >= RADIX_MIN && radix_reg <= RADIX_MAX))
        else $error("radix outside the supported range");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV) |-> (cnt_reg < limit_reg))
        else $error("digit count ran past its limit");

    a_pop_starts_div: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |=> (state_reg == ST_DIV))
        else $error("popped job did not start a division");

endmodule

`default_nettype wire

[bench/integer_to_ascii_any_base_checker.sv]
// Checker for the integer to ASCII converter: predicts the text of each input beat and compares.
module integer_to_ascii_any_base_checker #(
    parameter int unsigned MAX_DIGITS = itoa_pkg::DEFAULT_MAX_DIGITS
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic                s_ready,
    input  itoa_pkg::itoa_in_t  s_data,
    input  logic                m_valid,
    input  logic                m_ready,
    input  itoa_pkg::itoa_out_t m_data,
    output int                  mismatch_count,
    output int                  chars_waiting
);
    import itoa_pkg::*;

    // Characters still owed by the block, oldest first.
    itoa_out_t expected_chars[$];

    // Works out the full text of one conversion and appends it to the queue.
    function automatic void queue_text(input itoa_in_t job);
        logic                   negative;
        logic [VALUE_WIDTH-1:0] magnitude;
        logic [VALUE_WIDTH-1:0] rest;
        logic [VALUE_WIDTH-1:0] base;
        logic [RADIX_W-1:0]     clamped;
        logic [RADIX_W-1:0]     digits [MAX_DIGITS];
        logic [RADIX_W-1:0]     d;
        int unsigned            span;
        itoa_out_t              ch;

        negative  = job.value[VALUE_WIDTH-1];
        magnitude = job.value;
        if (negative) begin
            magnitude = ~magnitude + 1'b1;
        end

        clamped = job.radix;
        if (clamped < RADIX_MIN) begin
            clamped = RADIX_MIN;
        end else if (clamped > RADIX_MAX) begin
            clamped = RADIX_MAX;
        end
        base = VALUE_WIDTH'(clamped);

        if (job.digit_count == '0) begin
            span = 0;
            rest = magnitude;
            do begin
                rest = rest / base;
                span++;
            end while (rest != '0);
        end else begin
            span = 32'(job.digit_count);
        end
        if (span > MAX_DIGITS) begin
            span = MAX_DIGITS;
        end

        rest = magnitude;
        for (int unsigned i = 0; i < span; i++) begin
            digits[i] = RADIX_W'(rest % base);
            rest      = rest / base;
        end

        if (negative) begin
            ch.character = CH_MINUS;
            ch.last      = 1'b0;
            expected_chars.push_back(ch);
        end
        for (int unsigned i = span; i > 0; i--) begin
            d = digits[i-1];
            if (d >= DEC_LIMIT) begin
                ch.character = CH_ALPHA + CHAR_W'(d - DEC_LIMIT);
            end else begin
                ch.character = CH_ZERO + CHAR_W'(d);
            end
            ch.last = (i == 1);
            expected_chars.push_back(ch);
        end
    endfunction

    always @(posedge aclk) begin
        itoa_out_t wanted;
        if (!aresetn) begin
            expected_chars.delete();
            mismatch_count = 0;
            chars_waiting <= 0;
        end else begin
            if (s_valid && s_ready) begin
                queue_text(s_data);
            end
            if (m_valid && m_ready) begin
                if (expected_chars.size() == 0) begin
                    $display("%0t: unexpected beat: expected none, got character %h last %b",
                             $time, m_data.character, m_data.last);
                    mismatch_count++;
                end else begin
                    wanted = expected_chars.pop_front();
                    if (m_data.character !== wanted.character || m_data.last !== wanted.last)
                    begin
                        $display("%0t: mismatch: expected character %h last %b, got %h last %b",
                                 $time, wanted.character, wanted.last,
                                 m_data.character, m_data.last);
                        mismatch_count++;
                    end
                end
            end
            chars_waiting <= expected_chars.size();
        end
    end

endmodule

[bench/integer_to_ascii_any_base_core_test.sv]
// Testbench top for the integer to ASCII converter: drives stimulus and reports the verdict.
module integer_to_ascii_any_base_core_test;
    import itoa_pkg::*;

    // Watchdog limit; a correct run ends well before it is reached.
    localparam int unsigned RUN_LIMIT    = 1_000_000;
    // Enough for a full 32-digit conversion with a sign to leave the block.
    localparam int unsigned DRAIN_CYCLES = 250;
    localparam int unsigned BATCH_ITEMS  = 100;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    itoa_in_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    itoa_out_t m_data;

    int          mismatch_count;
    int          chars_waiting;
    int unsigned send_idle_pct = 0;
    int unsigned take_idle_pct = 0;
    int unsigned cycle_count   = 0;

    integer_to_ascii_any_base_core dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    integer_to_ascii_any_base_checker text_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data         (s_data),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_data         (m_data),
        .mismatch_count (mismatch_count),
        .chars_waiting  (chars_waiting)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    // The receiver drops ready at random; with a zero percentage it never stalls.
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= take_idle_pct);
    end

    // Watchdog: a hung block ends the run as a failure.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == RUN_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Offers one input beat, after an optional random gap, and returns once it is taken.
    // Valid is raised only in a step where it was not lowered, so it never glitches.
    task automatic send_conversion(input int value, input int unsigned radix,
                                   input int unsigned count);
        itoa_in_t job;
        job.value       = value;
        job.radix       = RADIX_W'(radix);
        job.digit_count = COUNT_W'(count);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= job;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Stops offering beats until every predicted character has left the block.
    task automatic hold_until_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (chars_waiting != 0);
    endtask

    // Random conversions: mostly ordinary radices and short lengths, with full-range
    // values, small values of either sign, values near the extremes, and now and then
    // an out-of-range radix or a digit count beyond the limit.
    task automatic random_batch(input int unsigned items);
        int          v;
        int unsigned pick;
        int unsigned base;
        int unsigned want;
        repeat (items) begin
            pick = $urandom_range(99);
            if (pick < 40) begin
                v = $urandom;
            end else if (pick < 65) begin
                v = $urandom_range(2000);
                if ($urandom_range(1)) begin
                    v = -v;
                end
            end else if (pick < 80) begin
                if ($urandom_range(1)) begin
                    v = int'(32'h7FFF_FFFF) - int'($urandom_range(3));
                end else begin
                    v = int'(32'h8000_0000) + int'($urandom_range(3));
                end
            end else begin
                v = int'($urandom) >>> 16;
            end

            base = ($urandom_range(9) == 0) ? $urandom_range(63) : $urandom_range(36, 2);

            pick = $urandom_range(99);
            if (pick < 40) begin
                want = 0;
            end else if (pick < 85) begin
                want = $urandom_range(12, 1);
            end else if (pick < 95) begin
                want = $urandom_range(32, 13);
            end else begin
                want = $urandom_range(63, 33);
            end

            send_conversion(v, base, want);
        end
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_idle_pct = 33;
        take_idle_pct = 75;

        // Directed part: zero, the extremes of the value, automatic length in several
        // radices, padding, truncation, saturation of the count and clamping of the radix.
        send_conversion(0, 10, 0);
        send_conversion(-1, 10, 0);
        send_conversion(int'(32'h7FFF_FFFF), 10, 0);
        send_conversion(int'(32'h8000_0000), 10, 0);
        send_conversion(int'(32'h8000_0000), 2, 0);
        send_conversion(int'(32'h7FFF_FFFF), 36, 0);
        send_conversion(255, 16, 0);
        send_conversion(35, 36, 0);
        send_conversion(5, 10, 8);
        send_conversion(0, 10, 5);
        send_conversion(123456, 10, 3);
        send_conversion(123, 10, 1);
        send_conversion(0, 36, 1);
        send_conversion(-1, 2, 32);
        send_conversion(7, 10, 33);
        send_conversion(-5, 3, 63);
        send_conversion(int'(32'h7FFF_FFFF), 2, 0);
        send_conversion(10, 0, 0);
        send_conversion(-10, 1, 0);
        send_conversion(1295, 37, 0);
        send_conversion(-1295, 63, 0);
        send_conversion(int'(32'h5555_5555), 4, 0);
        send_conversion(int'(32'hAAAA_AAAA), 8, 0);
        send_conversion(int'(32'h8000_0000), 36, 20);

        random_batch(BATCH_ITEMS);
        hold_until_drained();

        send_idle_pct = 75;
        take_idle_pct = 33;
        random_batch(BATCH_ITEMS);
        hold_until_drained();

        send_idle_pct = 0;
        take_idle_pct = 0;
        random_batch(BATCH_ITEMS);

        hold_until_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatch_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
